[rtl/core/bta_pkg.sv]
// Shared codes and field widths for the boundary tag heap allocator.
`default_nettype none
package bta_pkg;
  localparam int ADDR_W = 32;
  localparam int REQ_W  = 13;
  localparam int NEED_W = 14;
  localparam int STAT_W = 2;

  // command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOFIT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ZERO  = 2'd2;

  // tag flag bit positions
  localparam int TAG_FREE_BIT = 0;
  localparam int TAG_PREV_BIT = 1;

  // smallest remainder worth splitting off
  localparam int MIN_SPLIT = 8;
endpackage
`default_nettype wire

[rtl/core/bta_tag_ram.sv]
// Tag store: one write port, one registered read port.
`default_nettype none
module bta_tag_ram #(
  parameter int DEPTH = 1024,
  parameter int IDX_W = 10,
  parameter int TAG_W = 13
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_idx,
  input  wire logic [TAG_W-1:0] wr_data,
  input  wire logic [IDX_W-1:0] rd_idx,
  output logic      [TAG_W-1:0] rd_data
);
  logic [TAG_W-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_data <= mem[rd_idx];
  end
endmodule
`default_nettype wire

[rtl/core/boundary_tag_heap_allocator.sv]
// Top level: first-fit boundary tag heap allocator with a block-walk sequencer.
//
//  channel | signals                                               | handshake
//  --------+-------------------------------------------------------+------------------
//  in      | in_command, in_request_size, in_free_address           | start && !busy
//  out     | out_content_address, out_status                        | out_valid, 1 cycle
//  cfg     | cfg_wdata (heap_base)                                  | cfg_we
//
// A transaction walks the block chain from offset 0, each block visited with
// a tag read, then a check, through the single tag store read port. An
// allocate that hits a block splits it, or hands it over whole and updates
// the next block's tag; a free reads the next block's tag unless the freed
// block is the last one, then writes the merged tags. Zero-size allocates
// and out-of-range or misaligned frees answer straight from idle, with no walk.
// After reset the S_INIT state writes the initial heap tag while busy is high.
// Results cannot be stalled: out_valid is a one-cycle strobe.
`default_nettype none
module boundary_tag_heap_allocator
  import bta_pkg::*;
#(
  parameter int HEAP_BYTES = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              in_command,
  input  wire logic [REQ_W-1:0]  in_request_size,
  input  wire logic [ADDR_W-1:0] in_free_address,
  output logic                   out_valid,
  output logic [ADDR_W-1:0]      out_content_address,
  output logic [STAT_W-1:0]      out_status,
  input  wire logic              cfg_we,
  input  wire logic [ADDR_W-1:0] cfg_wdata
);
  localparam int OFF_W     = $clog2(HEAP_BYTES) + 1;
  localparam int TAG_W     = OFF_W;
  localparam int TAG_WORDS = HEAP_BYTES / 4;
  localparam int IDX_W     = $clog2(TAG_WORDS);
  localparam int CW        = ((OFF_W > NEED_W) ? OFF_W : NEED_W) + 1;
  localparam logic [CW-1:0] HEAP_C = CW'(HEAP_BYTES);
  localparam logic [CW-1:0] FOUR_C = CW'(4);
  localparam logic [CW-1:0] SPLIT_C = CW'(MIN_SPLIT);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_RD, S_CHK, S_NRD, S_NCHK, S_MERGE, S_WR
  } state_t;

  state_t            state_r;
  logic              cmd_r;
  logic [CW-1:0]     need_r, target_r, off_r, nx_r, prev_r, start_r, total_r;
  logic [TAG_W-1:0]  prev_tag_r, cur_tag_r;
  logic              have_prev_r;
  logic [ADDR_W-1:0] base_r, caddr_r;
  logic [STAT_W-1:0] status_r;
  logic [2:0]        wv_r;
  logic [IDX_W-1:0]  wa_r [3];
  logic [TAG_W-1:0]  wd_r [3];
  logic [1:0]        wk_r;
  logic              out_valid_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [STAT_W-1:0] out_status_r;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx, rd_idx;
  logic [TAG_W-1:0]  wr_data, rd_tag;
  logic [CW-1:0]     rd_size, sane_off, off_sum, nx_sum;
  logic              rd_sane;
  logic [NEED_W-1:0] req_up;
  logic [ADDR_W-1:0] rel, target;
  logic              free_ok, merge;
  logic [CW-1:0]     m_start, m_total;
  logic [TAG_W-1:0]  m_tag;

  function automatic logic [TAG_W-1:0] mk_tag(input logic [CW-1:0] size,
                                              input logic prev, input logic free);
    mk_tag = {size[TAG_W-1:2], prev, free};
  endfunction

  function automatic logic [IDX_W-1:0] idx_of(input logic [CW-1:0] off);
    idx_of = off[IDX_W+1:2];
  endfunction

  // tag decode and sanity check
  assign rd_size  = CW'({rd_tag[TAG_W-1:2], 2'b00});
  assign sane_off = (state_r == S_NCHK) ? nx_r : off_r;
  assign rd_sane  = (rd_size >= FOUR_C) && (rd_size <= HEAP_C - sane_off);
  assign off_sum  = off_r + rd_size;
  assign nx_sum   = nx_r + rd_size;

  // request rounding and free address check
  assign req_up  = (NEED_W'(in_request_size) + NEED_W'(3)) & ~NEED_W'(3);
  assign rel     = in_free_address - base_r;
  assign target  = rel - 32'd4;
  assign free_ok = (rel >= 32'd4) && (target[1:0] == 2'b00) &&
                   (target < 32'(HEAP_BYTES));

  // merge with the previous block
  assign merge   = cur_tag_r[TAG_PREV_BIT] && have_prev_r && prev_tag_r[TAG_FREE_BIT];
  assign m_start = merge ? prev_r : start_r;
  assign m_total = total_r + (merge ? CW'({prev_tag_r[TAG_W-1:2], 2'b00}) : '0);
  assign m_tag   = mk_tag(m_total,
                          merge ? prev_tag_r[TAG_PREV_BIT] : cur_tag_r[TAG_PREV_BIT], 1'b1);

  // tag store ports
  assign wr_en   = (state_r == S_INIT) || ((state_r == S_WR) && wv_r[wk_r]);
  assign wr_idx  = (state_r == S_INIT) ? '0 : wa_r[wk_r];
  assign wr_data = (state_r == S_INIT) ? mk_tag(HEAP_C, 1'b0, 1'b1) : wd_r[wk_r];
  assign rd_idx  = (state_r == S_NRD) ? idx_of(nx_r) : idx_of(off_r);

  bta_tag_ram #(.DEPTH(TAG_WORDS), .IDX_W(IDX_W), .TAG_W(TAG_W)) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_idx (wr_idx),
    .wr_data(wr_data),
    .rd_idx (rd_idx),
    .rd_data(rd_tag)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
      base_r      <= '0;
      wv_r        <= '0;
      wk_r        <= '0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        base_r <= cfg_wdata;
      end
      unique case (state_r)
        S_INIT: begin
          state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            cmd_r       <= in_command;
            off_r       <= '0;
            have_prev_r <= 1'b0;
            wv_r        <= '0;
            wk_r        <= '0;
            caddr_r     <= '0;
            status_r    <= STAT_DONE;
            if (in_command == CMD_ALLOC) begin
              if (in_request_size == '0) begin
                out_valid_r  <= 1'b1;
                out_addr_r   <= '0;
                out_status_r <= STAT_ZERO;
              end else begin
                need_r  <= CW'(req_up + NEED_W'(4));
                state_r <= S_RD;
              end
            end else if (free_ok) begin
              target_r <= CW'(target[OFF_W-1:0]);
              state_r  <= S_RD;
            end else begin
              out_valid_r  <= 1'b1;
              out_addr_r   <= '0;
              out_status_r <= STAT_DONE;
            end
          end
        end
        S_RD: begin
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (cmd_r == CMD_ALLOC) begin
            if (!rd_sane) begin
              out_valid_r  <= 1'b1;
              out_addr_r   <= '0;
              out_status_r <= STAT_NOFIT;
              state_r      <= S_IDLE;
            end else if (rd_tag[TAG_FREE_BIT] && rd_size >= need_r) begin
              caddr_r  <= base_r + ADDR_W'(off_r) + 32'd4;
              status_r <= STAT_DONE;
              if (rd_size < need_r + SPLIT_C) begin
                // whole block handed over; next block loses its prev-free flag
                nx_r     <= off_sum;
                wv_r[2]  <= 1'b1;
                wa_r[2]  <= idx_of(off_r);
                wd_r[2]  <= mk_tag(rd_size, rd_tag[TAG_PREV_BIT], 1'b0);
                state_r  <= (off_sum < HEAP_C) ? S_NRD : S_WR;
              end else begin
                // split: remainder becomes a free block with footer
                wv_r    <= 3'b111;
                wa_r[0] <= idx_of(off_r + need_r);
                wd_r[0] <= mk_tag(rd_size - need_r, 1'b0, 1'b1);
                wa_r[1] <= idx_of(off_sum - FOUR_C);
                wd_r[1] <= mk_tag(rd_size - need_r, 1'b0, 1'b1);
                wa_r[2] <= idx_of(off_r);
                wd_r[2] <= mk_tag(need_r, rd_tag[TAG_PREV_BIT], 1'b0);
                state_r <= S_WR;
              end
            end else begin
              off_r <= off_sum;
              if (off_sum < HEAP_C) begin
                state_r <= S_RD;
              end else begin
                out_valid_r  <= 1'b1;
                out_addr_r   <= '0;
                out_status_r <= STAT_NOFIT;
                state_r      <= S_IDLE;
              end
            end
          end else begin
            if (!rd_sane || (off_r == target_r && rd_tag[TAG_FREE_BIT])) begin
              out_valid_r  <= 1'b1;
              out_addr_r   <= '0;
              out_status_r <= STAT_DONE;
              state_r      <= S_IDLE;
            end else if (off_r == target_r) begin
              cur_tag_r <= rd_tag;
              start_r   <= off_r;
              total_r   <= rd_size;
              nx_r      <= off_sum;
              state_r   <= (off_sum < HEAP_C) ? S_NRD : S_MERGE;
            end else begin
              prev_r      <= off_r;
              prev_tag_r  <= rd_tag;
              have_prev_r <= 1'b1;
              off_r       <= off_sum;
              if (off_sum < HEAP_C && off_sum <= target_r) begin
                state_r <= S_RD;
              end else begin
                out_valid_r  <= 1'b1;
                out_addr_r   <= '0;
                out_status_r <= STAT_DONE;
                state_r      <= S_IDLE;
              end
            end
          end
        end
        S_NRD: begin
          state_r <= S_NCHK;
        end
        S_NCHK: begin
          if (cmd_r == CMD_ALLOC) begin
            // clear prev-free on the next block, footer too if it is free
            wv_r[0] <= 1'b1;
            wa_r[0] <= idx_of(nx_r);
            wd_r[0] <= mk_tag(rd_size, 1'b0, rd_tag[TAG_FREE_BIT]);
            wv_r[1] <= rd_tag[TAG_FREE_BIT] && (rd_size >= FOUR_C);
            wa_r[1] <= idx_of(nx_sum - FOUR_C);
            wd_r[1] <= mk_tag(rd_size, 1'b0, rd_tag[TAG_FREE_BIT]);
            state_r <= S_WR;
          end else begin
            if (rd_tag[TAG_FREE_BIT] && rd_sane) begin
              total_r <= total_r + rd_size;
            end else begin
              wv_r[0] <= 1'b1;
              wa_r[0] <= idx_of(nx_r);
              wd_r[0] <= mk_tag(rd_size, 1'b1, rd_tag[TAG_FREE_BIT]);
            end
            state_r <= S_MERGE;
          end
        end
        S_MERGE: begin
          wv_r[2:1] <= 2'b11;
          wa_r[1]   <= idx_of(m_start);
          wd_r[1]   <= m_tag;
          wa_r[2]   <= idx_of(m_start + m_total - FOUR_C);
          wd_r[2]   <= m_tag;
          state_r   <= S_WR;
        end
        S_WR: begin
          if (wk_r == 2'd2) begin
            out_valid_r  <= 1'b1;
            out_addr_r   <= caddr_r;
            out_status_r <= status_r;
            wk_r         <= '0;
            state_r      <= S_IDLE;
          end else begin
            wk_r <= wk_r + 2'd1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_content_address = out_addr_r;
  assign out_status          = out_status_r;

  // checks
  a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_DONE) |-> (out_content_address == '0))
    else $error("failed request returned a nonzero address");

  a_walk_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command == CMD_ALLOC && in_request_size != '0) |=> busy)
    else $error("allocate did not start a walk");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STAT_DONE || out_status == STAT_NOFIT ||
                   out_status == STAT_ZERO))
    else $error("undefined status code");

  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (32'(wr_idx) < 32'(TAG_WORDS)))
    else $error("tag write beyond the store");
endmodule
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the boundary tag first-fit heap allocator.
`timescale 1ns / 1ps

module tb;
  import bta_pkg::*;

  localparam int HEAP = 4096;
  localparam int TAG_WORDS = HEAP / 4;
  localparam logic [31:0] SIZE_MASK = 32'hFFFF_FFFC;
  localparam logic [31:0] F_FREE = 32'h1;
  localparam logic [31:0] F_PREV = 32'h2;
  localparam longint CYCLE_LIMIT = 4000000;

  // Heap model: tag store copy, expected results and live allocations
  class heap_scoreboard;
    logic [31:0] tags [TAG_WORDS];
    logic [31:0] base;
    logic [31:0] exp_addr [$];
    logic [1:0]  exp_stat [$];
    logic [31:0] live [$];
    int errors, n_alloc, n_free_ok, n_nofit, n_zero, n_checked;

    function void write_tag(logic [31:0] off, logic [31:0] size, logic [31:0] flags);
      logic [31:0] t;
      t = (size & SIZE_MASK) | (flags & 32'h3);
      tags[(off >> 2) % TAG_WORDS] = t;
      if ((flags & F_FREE) != 0 && size >= 4)
        tags[((off + size - 4) >> 2) % TAG_WORDS] = t;
    endfunction

    function logic [31:0] read_tag(logic [31:0] off);
      return tags[(off >> 2) % TAG_WORDS];
    endfunction

    function bit sane(logic [31:0] off, logic [31:0] size);
      return size >= 4 && off < HEAP && size <= HEAP - off;
    endfunction

    function void reset_heap();
      foreach (tags[i]) tags[i] = '0;
      base = '0;
      live.delete();
      write_tag(0, HEAP, F_FREE);
    endfunction

    // first-fit walk; returns 1 and the block offset on a hit
    function bit first_fit(logic [31:0] need, output logic [31:0] where);
      logic [31:0] off, t, sz, nx, nt;
      off = 0;
      where = 0;
      while (off < HEAP) begin
        t = read_tag(off);
        sz = t & SIZE_MASK;
        if (!sane(off, sz)) return 0;
        if ((t & F_FREE) != 0 && sz >= need) begin
          if (sz < need + MIN_SPLIT) begin
            nx = off + sz;
            if (nx < HEAP) begin
              nt = read_tag(nx);
              write_tag(nx, nt & SIZE_MASK, nt & F_FREE);
            end
            write_tag(off, sz, t & F_PREV);
          end else begin
            write_tag(off + need, sz - need, F_FREE);
            write_tag(off, need, t & F_PREV);
          end
          where = off;
          return 1;
        end
        off += sz;
      end
      return 0;
    endfunction

    // release and coalesce; returns 1 if a block was actually freed
    function bit release_block(logic [31:0] addr);
      logic [31:0] rel, target, off, prv, prv_tag, t, sz, start, total, flags, nx, nt, nsz;
      bit have_prev;
      rel = addr - base;
      off = 0; prv = 0; prv_tag = 0; have_prev = 0;
      if (rel < 4) return 0;
      target = rel - 4;
      if ((target & 32'h3) != 0 || target >= HEAP) return 0;
      while (off < HEAP && off <= target) begin
        t = read_tag(off);
        sz = t & SIZE_MASK;
        if (!sane(off, sz)) return 0;
        if (off == target) begin
          start = off; total = sz; flags = t & F_PREV;
          nx = off + sz;
          if ((t & F_FREE) != 0) return 0;
          if (nx < HEAP) begin
            nt = read_tag(nx);
            nsz = nt & SIZE_MASK;
            if ((nt & F_FREE) != 0 && sane(nx, nsz)) total += nsz;
            else write_tag(nx, nsz, (nt & 32'h3) | F_PREV);
          end
          if ((t & F_PREV) != 0 && have_prev && (prv_tag & F_FREE) != 0) begin
            start = prv;
            total += prv_tag & SIZE_MASK;
            flags = prv_tag & F_PREV;
          end
          write_tag(start, total, flags | F_FREE);
          for (int i = 0; i < live.size(); i++)
            if (live[i] == target) begin
              live.delete(i);
              break;
            end
          return 1;
        end
        prv = off; prv_tag = t; have_prev = 1;
        off += sz;
      end
      return 0;
    endfunction

    // accepted input transaction: predict its result
    function void note_input(logic cmd, logic [12:0] req, logic [31:0] addr);
      logic [31:0] need, where, ca;
      logic [1:0] st;
      ca = '0;
      st = STAT_DONE;
      if (cmd == CMD_ALLOC) begin
        if (req == 0) begin
          st = STAT_ZERO;
          n_zero++;
        end else begin
          need = 4 + ((32'(req) + 3) & SIZE_MASK);
          if (first_fit(need, where)) begin
            ca = base + where + 4;
            live.push_back(where);
            n_alloc++;
          end else begin
            st = STAT_NOFIT;
            n_nofit++;
          end
        end
      end else if (release_block(addr)) begin
        n_free_ok++;
      end
      exp_addr.push_back(ca);
      exp_stat.push_back(st);
    endfunction

    // result transaction: compare with the oldest prediction
    function void check_result(logic [31:0] ca, logic [1:0] st);
      logic [31:0] ea;
      logic [1:0] es;
      if (exp_addr.size() == 0) begin
        $display("%0t: unexpected result addr=%h status=%0d", $time, ca, st);
        errors++;
        return;
      end
      ea = exp_addr.pop_front();
      es = exp_stat.pop_front();
      n_checked++;
      if (ca !== ea) begin
        $display("%0t: content_address expected %h actual %h", $time, ea, ca);
        errors++;
      end
      if (st !== es) begin
        $display("%0t: status expected %0d actual %0d", $time, es, st);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_command = CMD_ALLOC;
  logic [REQ_W-1:0] in_request_size = '0;
  logic [ADDR_W-1:0] in_free_address = '0;
  logic out_valid;
  logic [ADDR_W-1:0] out_content_address;
  logic [STAT_W-1:0] out_status;
  logic cfg_we = 1'b0;
  logic [ADDR_W-1:0] cfg_wdata = '0;

  heap_scoreboard sb = new();
  int idle_pct;
  longint cycles;

  boundary_tag_heap_allocator #(.HEAP_BYTES(HEAP)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_request_size(in_request_size),
    .in_free_address(in_free_address),
    .out_valid(out_valid), .out_content_address(out_content_address),
    .out_status(out_status),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_content_address, out_status);
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // one command transaction, with an optional idle gap in front
  task automatic issue(logic cmd, logic [12:0] req, logic [31:0] addr);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_command <= cmd;
    in_request_size <= req;
    in_free_address <= addr;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_input(cmd, req, addr);
  endtask

  task automatic alloc(int req);
    issue(CMD_ALLOC, 13'(req), $urandom);
  endtask

  task automatic free_at(logic [31:0] off);
    issue(CMD_FREE, 13'($urandom), sb.base + off + 4);
  endtask

  // drain, then reprogram heap_base while idle
  task automatic set_base(logic [31:0] v);
    start <= 1'b0;
    while (sb.exp_addr.size() != 0 || busy) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.base = v;
  endtask

  // random mix: mostly valid alloc/free pairs, some bad frees
  task automatic run_random(int n);
    int r, k;
    logic [31:0] a;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 42 && sb.live.size() != 0) begin
        k = $urandom_range(sb.live.size() - 1);
        free_at(sb.live[k]);
      end else if (r < 50) begin
        case ($urandom_range(3))
          0: a = $urandom;
          1: a = sb.base + 4 + ($urandom_range(HEAP - 1) & SIZE_MASK);
          2: a = sb.base + $urandom_range(HEAP + 8);
          default: a = sb.base + $urandom_range(3);
        endcase
        issue(CMD_FREE, 13'($urandom), a);
      end else begin
        r = $urandom_range(99);
        if (r < 3) alloc(0);
        else if (r < 5) alloc(HEAP);
        else if (r < 8) alloc($urandom_range(HEAP, 1));
        else if (r < 25) alloc($urandom_range(512, 1));
        else alloc($urandom_range(64, 1));
      end
    end
  endtask

  initial begin
    logic [31:0] bases [5];
    int modes [5];
    bases = '{32'h0, 32'hFFFF_FFFC, 32'h0, 32'h0001_0000, 32'h0};
    bases[2] = $urandom;
    modes = '{0, 63, 0, 34, 63};
    idle_pct = 0;
    cycles = 0;
    sb.reset_heap();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    set_base(32'h0);

    // directed: splits, merges, bad frees, exact fit, no fit, zero size
    alloc(1); alloc(5); alloc(8); alloc(13);
    free_at(8);                      // lone free
    free_at(20);                     // merge with previous
    free_at(0);                      // merge with next
    free_at(0);                      // double free
    issue(CMD_FREE, '0, 32'd37);     // misaligned
    issue(CMD_FREE, '0, 32'd2);      // below heap start
    issue(CMD_FREE, '0, 32'hFFFF_FFF0);
    free_at(32);                     // merge both sides
    alloc(4092);                     // whole heap
    alloc(1);                        // no fit
    free_at(0);
    alloc(0);
    alloc(4096);                     // too large
    alloc(4084);                     // leaves exactly a minimal block
    alloc(1);                        // takes that remainder
    free_at(4088);
    free_at(0);
    alloc(4089);                     // no split: remainder too small
    free_at(0);
    issue(CMD_FREE, 13'h1FFF, 32'h0000_0008);  // inside the free heap

    for (int p = 0; p < 5; p++) begin
      idle_pct = 0;
      set_base(bases[p]);
      idle_pct = modes[p];
      run_random(200);
    end

    start <= 1'b0;
    while (sb.exp_addr.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Covered %0d allocs, %0d frees, %0d no-fit, %0d zero-size; %0d results checked.",
             sb.n_alloc, sb.n_free_ok, sb.n_nofit, sb.n_zero, sb.n_checked);
    if (sb.errors == 0 && sb.exp_addr.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
